### rtl/core/idc_pkg.sv
// Shared types, constants and the exponential table function of the duty core.
package idc_pkg;

    // Field widths
    localparam int CHAN_W  = 8;
    localparam int VOLT_W  = 16;
    localparam int CUR_W   = 16;
    localparam int DUTY_W  = 18;
    localparam int VDC_W   = 15;
    localparam int AMP_W   = 16;
    localparam int TAU_W   = 16;
    localparam int STATE_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Default table depth
    localparam int EXP_TABLE_DEPTH_DEF = 256;

    // Divider geometry: quotient bits and bits resolved per stage
    localparam int VDIV_NUM_W = 32;
    localparam int VDIV_STEPS = 4;
    localparam int TDIV_NUM_W = 24;
    localparam int TDIV_STEPS = 3;
    localparam int DIV_STAGES = VDIV_NUM_W / VDIV_STEPS;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_VOLTAGE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMP_AMP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMP_TAU     = 2'd2;

    // Clamp direction codes
    localparam logic [STATE_W-1:0] CLAMP_NONE = 2'd0;
    localparam logic [STATE_W-1:0] CLAMP_LOW  = 2'd1;
    localparam logic [STATE_W-1:0] CLAMP_HIGH = 2'd2;

    // Duty limits and midpoint
    localparam logic signed [DUTY_W-1:0] DUTY_MIN  = -18'sd131072;
    localparam logic signed [DUTY_W-1:0] DUTY_MAX  = 18'sd131071;
    localparam logic signed [DUTY_W-1:0] DUTY_HALF = 18'sd32768;

    // Base duty quotient saturation point (beyond it the duty saturates anyway)
    localparam int QSAT_W = 19;
    localparam logic [QSAT_W-1:0] QSAT = 19'h40000;

    // Exponential decay per table step, Q32
    localparam logic [63:0] EXP_DECAY_Q32 = 64'd4162825044;

    // Per-item side data carried down the pipeline
    typedef struct packed {
        logic [CHAN_W-1:0]        channel;
        logic signed [VOLT_W-1:0] cv;
        logic [STATE_W-1:0]       state;
        logic                     err;
        logic                     v_neg;
        logic                     cur_neg;
        logic                     cur_zero;
    } t_side;

    // Table entry k: Q16 value of exp(-k/32) from the Q32 recurrence
    function automatic logic [16:0] exp_entry(input int k);
        logic [63:0] a;
        logic [63:0] s;
        a = 64'h1_0000_0000;
        for (int n = 0; n < k; n++) begin
            a = (a * EXP_DECAY_Q32 + 64'h8000_0000) >> 32;
        end
        s = (a + 64'd32768) >> 16;
        return s[16:0];
    endfunction

endpackage

### rtl/core/inverter_duty_with_deadtime_comp_core.sv
// PWM duty with dead-time compensation: twelve-stage streaming pipeline.
//
// Input stream: one transfer per phase update, tuser carries the PWM channel,
// tdata the voltage command and the phase current. Output stream: one transfer
// per input with the compensated duty, the voltage limited to the bus, the
// clamp direction and the zero-bus flag.
// Configuration: a write on the cfg channel sets bus voltage (index 0),
// compensation amplitude (1) or compensation current scale (2). cfg_ready is
// always high; write only while no item is in flight.
// Throughput: one item per cycle while the receiver does not stall. The depth
// is set by the two dividers (bus voltage and current scale), eight stages each,
// followed by the table read, the compensation multiply and the final sum and
// saturation. When the receiver stalls, items close up into empty stages; tready
// falls only when every stage holds an item.
// Reset clears all valid bits and the three registers to zero.
module inverter_duty_with_deadtime_comp_core #(
    parameter int EXP_TABLE_DEPTH = idc_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // Input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [15:0] voltage_command, [31:16] phase_current
    input  logic [7:0]  i_s_axis_tuser,   // [7:0] channel
    // Output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [17:0] duty, [33:18] clamped_voltage, [39:34] 0
    output logic [10:0] o_m_axis_tuser    // [7:0] out_channel, [9:8] clamp_state,
                                          // [10] bus_zero_error
);

    localparam int IDX_W   = $clog2(EXP_TABLE_DEPTH);
    localparam int DIV_STG = idc_pkg::DIV_STAGES;
    localparam int ST_ROM  = DIV_STG + 1;
    localparam int ST_MUL  = DIV_STG + 2;
    localparam int ST_OUT  = DIV_STG + 3;
    localparam int NSTG    = DIV_STG + 4;

    // Configuration registers
    logic [idc_pkg::VDC_W-1:0]        r_vdc;
    logic signed [idc_pkg::AMP_W-1:0] r_amp;
    logic [idc_pkg::TAU_W-1:0]        r_tau;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vdc <= '0;
            r_amp <= '0;
            r_tau <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                idc_pkg::CFG_BUS_VOLTAGE: r_vdc <= i_cfg_data[idc_pkg::VDC_W-1:0];
                idc_pkg::CFG_COMP_AMP:    r_amp <= i_cfg_data;
                idc_pkg::CFG_COMP_TAU:    r_tau <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline control
    logic [NSTG-1:0] w_en;

    idc_pipe_ctl #(
        .STAGES (NSTG)
    ) u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_en        (w_en),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid)
    );

    // Stage 0: magnitudes, divider numerators, voltage clamp
    logic signed [15:0] w_v;
    logic signed [15:0] w_cur;
    logic [15:0]        w_av;
    logic [15:0]        w_ai;
    logic signed [16:0] w_v17;
    logic signed [16:0] w_vdc17;
    logic [31:0]        n_num_v;
    logic [23:0]        n_num_t;
    idc_pkg::t_side     n_side;
    logic [31:0]        r_num_v;
    logic [23:0]        r_num_t;
    idc_pkg::t_side     r_side [NSTG];

    assign w_v     = i_s_axis_tdata[15:0];
    assign w_cur   = i_s_axis_tdata[31:16];
    assign w_av    = w_v[15] ? 16'(-w_v) : 16'(w_v);
    assign w_ai    = w_cur[15] ? 16'(-w_cur) : 16'(w_cur);
    assign w_v17   = 17'(w_v);
    assign w_vdc17 = 17'(signed'({2'b00, r_vdc}));
    assign n_num_v = {w_av, 16'h0000} + 32'(r_vdc);
    assign n_num_t = 24'({w_ai, 5'b00000});

    always_comb begin
        n_side.channel  = i_s_axis_tuser;
        n_side.cv       = w_v;
        n_side.state    = idc_pkg::CLAMP_NONE;
        n_side.err      = (r_vdc == '0);
        n_side.v_neg    = w_v[15];
        n_side.cur_neg  = w_cur[15];
        n_side.cur_zero = (w_cur == '0);
        if (w_v17 < -w_vdc17) begin
            n_side.cv    = 16'(-w_vdc17);
            n_side.state = idc_pkg::CLAMP_LOW;
        end else if (w_v17 > w_vdc17) begin
            n_side.cv    = 16'(w_vdc17);
            n_side.state = idc_pkg::CLAMP_HIGH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_num_v <= n_num_v;
            r_num_t <= n_num_t;
        end
    end

    // Carry side data down every stage
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_side[0] <= n_side;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (w_en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Stages 1..8: the two dividers
    logic [31:0] w_q_v;
    logic [23:0] w_q_t;

    idc_div #(
        .NUM_W (idc_pkg::VDIV_NUM_W),
        .DEN_W (16),
        .STEPS (idc_pkg::VDIV_STEPS)
    ) u_div_v (
        .i_clk (i_clk),
        .i_en  (w_en[DIV_STG:1]),
        .i_num (r_num_v),
        .i_den ({r_vdc, 1'b0}),
        .o_quo (w_q_v)
    );

    idc_div #(
        .NUM_W (idc_pkg::TDIV_NUM_W),
        .DEN_W (idc_pkg::TAU_W),
        .STEPS (idc_pkg::TDIV_STEPS)
    ) u_div_t (
        .i_clk (i_clk),
        .i_en  (w_en[DIV_STG:1]),
        .i_num (r_num_t),
        .i_den (r_tau),
        .o_quo (w_q_t)
    );

    // Stage 9: saturate base quotient, clamp table index, read table
    logic [IDX_W-1:0]               w_idx;
    logic [16:0]                    w_e;
    logic [idc_pkg::QSAT_W-1:0]     r_qs_a;
    logic [idc_pkg::QSAT_W-1:0]     r_qs_b;

    assign w_idx = (w_q_t > 24'(EXP_TABLE_DEPTH - 1)) ? IDX_W'(EXP_TABLE_DEPTH - 1)
                                                       : w_q_t[IDX_W-1:0];

    idc_exp_rom #(
        .DEPTH (EXP_TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (w_en[ST_ROM]),
        .i_idx  (w_idx),
        .o_data (w_e)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[ST_ROM]) begin
            r_qs_a <= (w_q_v > 32'(idc_pkg::QSAT)) ? idc_pkg::QSAT
                                                   : w_q_v[idc_pkg::QSAT_W-1:0];
        end
    end

    // Stage 10: compensation magnitude product
    logic [16:0] w_aa;
    logic [33:0] r_prod;

    assign w_aa = r_amp[15] ? 17'(-17'(r_amp)) : 17'(r_amp);

    always_ff @(posedge i_clk) begin
        if (w_en[ST_MUL]) begin
            r_prod <= w_aa * (17'd65536 - w_e);
            r_qs_b <= r_qs_a;
        end
    end

    // Stage 11: compensation term, sum, saturation
    idc_pkg::t_side             w_s;
    logic [33:0]                w_rnd;
    logic signed [17:0]         w_m;
    logic signed [17:0]         w_term;
    logic signed [20:0]         w_q;
    logic signed [20:0]         w_sum;
    logic signed [17:0]         n_duty;
    logic signed [17:0]         r_duty;

    assign w_s   = r_side[ST_MUL];
    assign w_rnd = (r_prod + 34'd32768) >> 16;
    assign w_m   = 18'(signed'({1'b0, w_rnd[16:0]}));
    assign w_q   = w_s.v_neg ? -21'(signed'({2'b00, r_qs_b})) : 21'(signed'({2'b00, r_qs_b}));

    always_comb begin
        if ((r_amp == '0 && r_tau == '0) || w_s.cur_zero) begin
            w_term = '0;
        end else if (r_tau == '0) begin
            w_term = w_s.cur_neg ? -18'(r_amp) : 18'(r_amp);
        end else if (r_amp[15] != w_s.cur_neg) begin
            w_term = -w_m;
        end else begin
            w_term = w_m;
        end
    end

    assign w_sum = 21'(idc_pkg::DUTY_HALF) + w_q + 21'(w_term);

    always_comb begin
        if (w_s.err) begin
            n_duty = idc_pkg::DUTY_HALF;
        end else if (w_sum < 21'(idc_pkg::DUTY_MIN)) begin
            n_duty = idc_pkg::DUTY_MIN;
        end else if (w_sum > 21'(idc_pkg::DUTY_MAX)) begin
            n_duty = idc_pkg::DUTY_MAX;
        end else begin
            n_duty = w_sum[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            r_duty <= n_duty;
        end
    end

    // Drive result ports
    idc_pkg::t_side w_o;

    assign w_o            = r_side[ST_OUT];
    assign o_m_axis_tdata = {6'b000000, w_o.cv, r_duty};
    assign o_m_axis_tuser = {w_o.err, w_o.state, w_o.channel};

`ifndef SYNTHESIS
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_err_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && w_o.err) |-> (r_duty == idc_pkg::DUTY_HALF))
        else $error("zero bus voltage without half duty");

    a_state_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_o.state == idc_pkg::CLAMP_NONE ||
                             w_o.state == idc_pkg::CLAMP_LOW ||
                             w_o.state == idc_pkg::CLAMP_HIGH))
        else $error("bad clamp direction");

    a_clamp_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && w_o.state == idc_pkg::CLAMP_HIGH) |->
        (w_o.cv == 16'(r_vdc)))
        else $error("high clamp not at bus voltage");
`endif

endmodule

### rtl/core/idc_pipe_ctl.sv
// Valid bits and per-stage load enables of the duty pipeline.
module idc_pipe_ctl #(
    parameter int STAGES = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    output logic [STAGES-1:0] o_en,
    output logic              o_in_ready,
    output logic              o_out_valid
);

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;

    // A stage loads when it is empty or its successor loads
    always_comb begin
        o_en[STAGES-1] = ~r_vld[STAGES-1] | i_out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            o_en[k] = ~r_vld[k] | o_en[k+1];
        end
    end

    // Advance valid bits with the data
    always_comb begin
        n_vld = r_vld;
        if (o_en[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (o_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = o_en[0];
    assign o_out_valid = r_vld[STAGES-1];

endmodule

### rtl/core/idc_div.sv
// Pipelined restoring divider, a few quotient bits per stage, static divisor.
module idc_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16,
    parameter int STEPS = 4
) (
    input  logic                       i_clk,
    input  logic [NUM_W/STEPS-1:0]     i_en,
    input  logic [NUM_W-1:0]           i_num,
    input  logic [DEN_W-1:0]           i_den,
    output logic [NUM_W-1:0]           o_quo
);

    localparam int STG = NUM_W / STEPS;

    // Numerator shifts out at the top while quotient bits shift in below
    for (genvar s = 0; s < STG; s++) begin : g_stage
        logic [NUM_W-1:0] r_num;
        logic [DEN_W-1:0] r_rem;
        logic [NUM_W-1:0] w_num_in;
        logic [DEN_W-1:0] w_rem_in;
        logic [NUM_W-1:0] n_num;
        logic [DEN_W-1:0] n_rem;

        if (s == 0) begin : g_first
            assign w_num_in = i_num;
            assign w_rem_in = '0;
        end else begin : g_next
            assign w_num_in = g_stage[s-1].r_num;
            assign w_rem_in = g_stage[s-1].r_rem;
        end

        // Resolve STEPS quotient bits
        always_comb begin
            logic [DEN_W:0] v_t;
            n_num = w_num_in;
            n_rem = w_rem_in;
            for (int j = 0; j < STEPS; j++) begin
                v_t   = {n_rem, n_num[NUM_W-1]};
                n_num = {n_num[NUM_W-2:0], 1'b0};
                if (v_t >= {1'b0, i_den}) begin
                    v_t      = v_t - {1'b0, i_den};
                    n_num[0] = 1'b1;
                end
                n_rem = v_t[DEN_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_num <= n_num;
                r_rem <= n_rem;
            end
        end
    end

    assign o_quo = g_stage[STG-1].r_num;

endmodule

### rtl/core/idc_exp_rom.sv
// Exponential decay table with registered read.
module idc_exp_rom #(
    parameter int DEPTH = idc_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [$clog2(DEPTH)-1:0] i_idx,
    output logic [16:0]              o_data
);

    logic [16:0] w_tab [DEPTH];
    logic [16:0] r_data;

    // Fill entries from the recurrence at elaboration
    for (genvar k = 0; k < DEPTH; k++) begin : g_tab
        assign w_tab[k] = idc_pkg::exp_entry(k);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_tab[i_idx];
        end
    end

    assign o_data = r_data;

endmodule

### dv/inverter_duty_with_deadtime_comp_core_tb.sv
// Testbench for the dead-time compensated PWM duty core: directed and random checks.
`timescale 1ns / 100ps

module inverter_duty_with_deadtime_comp_core_tb;

    localparam int LATENCY     = 11;
    localparam int RANDOM_ITEMS = 1830;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAB_DEPTH   = idc_pkg::EXP_TABLE_DEPTH_DEF;

    typedef struct packed {
        logic [idc_pkg::CHAN_W-1:0]        channel;
        logic signed [idc_pkg::DUTY_W-1:0] duty;
        logic signed [idc_pkg::VOLT_W-1:0] cv;
        logic [idc_pkg::STATE_W-1:0]       state;
        logic                              err;
    } t_duty_result;

    // Directed row: register setting, input item, and an optional typed-in result
    typedef struct {
        logic [idc_pkg::VDC_W-1:0]  vdc;
        logic [idc_pkg::AMP_W-1:0]  amp;
        logic [idc_pkg::TAU_W-1:0]  tau;
        logic [7:0]        chan;
        logic [15:0]       v;
        logic [15:0]       cur;
        bit                fixed;
        logic [17:0]       duty;
        logic [15:0]       cv;
        logic [1:0]        state;
        logic              err;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;
    logic [7:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;
    logic [10:0] o_m_axis_tuser;

    inverter_duty_with_deadtime_comp_core uut (.*);

    always #1 i_clk = ~i_clk;

    // Predictor copy of the registers and the exponential table
    logic [idc_pkg::VDC_W-1:0]        bus_v;
    logic signed [idc_pkg::AMP_W-1:0] comp_amp;
    logic [idc_pkg::TAU_W-1:0]        comp_tau;
    logic [16:0]                      exp_rom [TAB_DEPTH];

    t_duty_result duty_queue[$];
    int  fail_count = 0;
    int  cycle_count = 0;
    bit  sink_idle_en = 1'b1;
    bit  src_idle_en = 1'b1;
    bit  long_hold = 1'b0;
    bit  stim_done = 1'b0;

    // Dead-time compensation term for one current sample
    function automatic longint dt_term(longint cur);
        longint amp, ai, aa, idx, m;
        amp = comp_amp;
        if (amp == 0 && comp_tau == 0) return 0;
        if (cur == 0) return 0;
        if (comp_tau == 0) return cur > 0 ? amp : -amp;
        ai = cur < 0 ? -cur : cur;
        aa = amp < 0 ? -amp : amp;
        idx = (ai * 32) / comp_tau;
        if (idx > TAB_DEPTH - 1) idx = TAB_DEPTH - 1;
        m = (aa * (65536 - longint'(exp_rom[idx])) + 32768) >>> 16;
        return ((amp < 0) != (cur < 0)) ? -m : m;
    endfunction

    // Duty, clamped voltage and flags for one item
    function automatic t_duty_result predict_duty(logic [7:0] chan, logic [15:0] vin,
                                                  logic [15:0] cin);
        t_duty_result r;
        longint v, cur, vdc, q, d, av;
        v = longint'($signed(vin));
        cur = longint'($signed(cin));
        vdc = bus_v;
        r.channel = chan;
        r.err = (vdc == 0);
        r.state = idc_pkg::CLAMP_NONE;
        if (vdc == 0) begin
            d = 32768;
        end else begin
            av = v < 0 ? -v : v;
            q = (av * 65536 + vdc) / (2 * vdc);
            d = 32768 + (v < 0 ? -q : q) + dt_term(cur);
            if (d < -131072) d = -131072;
            if (d > 131071) d = 131071;
        end
        r.duty = d[17:0];
        r.cv = vin;
        if (v < -vdc) begin
            r.cv = 16'(-vdc);
            r.state = idc_pkg::CLAMP_LOW;
        end else if (v > vdc) begin
            r.cv = 16'(vdc);
            r.state = idc_pkg::CLAMP_HIGH;
        end
        return r;
    endfunction

    // Table in the same fixed-point recurrence, computed independently
    initial begin
        longint unsigned a;
        a = 64'h1_0000_0000;
        for (int k = 0; k < TAB_DEPTH; k++) begin
            exp_rom[k] = 17'((a + 32768) >> 16);
            a = (a * 64'd4162825044 + 64'h8000_0000) >> 32;
        end
    end

    // Cycle counter and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                i_m_axis_tready <= 1'b0;
                repeat (60) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 12);
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Compare each output transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_duty_result got, exp_r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.duty = o_m_axis_tdata[17:0];
            got.cv = o_m_axis_tdata[33:18];
            got.channel = o_m_axis_tuser[7:0];
            got.state = o_m_axis_tuser[9:8];
            got.err = o_m_axis_tuser[10];
            if (duty_queue.size() == 0) begin
                $display("%0t unexpected result: actual %h", $time, got);
                fail_count++;
            end else begin
                exp_r = duty_queue.pop_front();
                if (got.channel !== exp_r.channel) begin
                    $display("%0t channel expected %0d actual %0d", $time,
                             exp_r.channel, got.channel);
                    fail_count++;
                end
                if (got.duty !== exp_r.duty) begin
                    $display("%0t duty expected %0d actual %0d", $time,
                             exp_r.duty, got.duty);
                    fail_count++;
                end
                if (got.cv !== exp_r.cv) begin
                    $display("%0t clamped voltage expected %0d actual %0d", $time,
                             exp_r.cv, got.cv);
                    fail_count++;
                end
                if (got.state !== exp_r.state) begin
                    $display("%0t clamp state expected %0d actual %0d", $time,
                             exp_r.state, got.state);
                    fail_count++;
                end
                if (got.err !== exp_r.err) begin
                    $display("%0t bus zero flag expected %0b actual %0b", $time,
                             exp_r.err, got.err);
                    fail_count++;
                end
            end
        end
    end

    // Write one register while the block is idle
    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk iff o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            idc_pkg::CFG_BUS_VOLTAGE: bus_v = data[14:0];
            idc_pkg::CFG_COMP_AMP:    comp_amp = data;
            idc_pkg::CFG_COMP_TAU:    comp_tau = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Wait until every expected result is back, then let the pipeline drain
    task automatic drain_pipe();
        while (duty_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [14:0] vdc, logic [15:0] amp, logic [15:0] tau);
        drain_pipe();
        if (vdc != bus_v) write_reg(idc_pkg::CFG_BUS_VOLTAGE, {1'b0, vdc});
        if (amp != comp_amp) write_reg(idc_pkg::CFG_COMP_AMP, amp);
        if (tau != comp_tau) write_reg(idc_pkg::CFG_COMP_TAU, tau);
    endtask

    // Offer one item, with an optional random gap first
    task automatic send_item(logic [7:0] chan, logic [15:0] v, logic [15:0] cur,
                             t_duty_result expd);
        int gap;
        if (src_idle_en && $urandom_range(0, 6) == 0) begin
            gap = $urandom_range(1, 12);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= chan;
        i_s_axis_tdata <= {cur, v};
        @(posedge i_clk iff o_s_axis_tready);
        duty_queue.push_back(expd);
    endtask

    task automatic send_pred(logic [7:0] chan, logic [15:0] v, logic [15:0] cur);
        send_item(chan, v, cur, predict_duty(chan, v, cur));
    endtask

    t_row rows[$];

    task automatic add_row(logic [14:0] vdc, logic [15:0] amp, logic [15:0] tau,
                           logic [7:0] chan, logic [15:0] v, logic [15:0] cur, bit fixed,
                           logic [17:0] duty, logic [15:0] cv, logic [1:0] st, logic err);
        t_row r;
        r = '{vdc, amp, tau, chan, v, cur, fixed, duty, cv, st, err};
        rows.push_back(r);
    endtask

    initial begin
        t_duty_result expd;
        logic [14:0] vdc;
        logic [15:0] amp, tau, v, cur;
        bus_v = '0;
        comp_amp = '0;
        comp_tau = '0;

        // Directed table: typed-in results where obvious, predictor elsewhere
        add_row(0, 0, 0, 8'h00, 16'h0000, 16'h0000, 1, 18'd32768, 16'd0,
                idc_pkg::CLAMP_NONE, 1);
        add_row(0, 0, 0, 8'hFF, 16'h8000, 16'h7FFF, 1, 18'd32768, 16'd0,
                idc_pkg::CLAMP_LOW, 1);
        add_row(0, 0, 0, 8'hA5, 16'h7FFF, 16'h8000, 1, 18'd32768, 16'd0,
                idc_pkg::CLAMP_HIGH, 1);
        add_row(100, 0, 0, 8'h01, 16'd100, 16'd0, 1, 18'd65536, 16'd100,
                idc_pkg::CLAMP_NONE, 0);
        add_row(100, 0, 0, 8'h02, -16'sd100, 16'd0, 1, 18'd0, -16'sd100,
                idc_pkg::CLAMP_NONE, 0);
        add_row(100, 0, 0, 8'h03, 16'd50, 16'd0, 1, 18'd49152, 16'd50,
                idc_pkg::CLAMP_NONE, 0);
        add_row(1, 0, 0, 8'h04, 16'h7FFF, 16'd0, 1, 18'd131071, 16'd1,
                idc_pkg::CLAMP_HIGH, 0);
        add_row(1, 0, 0, 8'h05, 16'h8000, 16'd0, 1, 18'h20000, 16'hFFFF,
                idc_pkg::CLAMP_LOW, 0);
        add_row(32767, 0, 0, 8'h06, 16'h7FFF, 16'h1234, 0, 0, 0, 0, 0);
        add_row(32767, 0, 0, 8'h07, 16'h8000, 16'h8000, 0, 0, 0, 0, 0);
        add_row(1000, 16'd3000, 0, 8'h08, 16'd0, 16'd5, 1, 18'd35768, 16'd0,
                idc_pkg::CLAMP_NONE, 0);
        add_row(1000, 16'd3000, 0, 8'h09, 16'd0, -16'sd5, 1, 18'd29768, 16'd0,
                idc_pkg::CLAMP_NONE, 0);
        add_row(1000, 16'd3000, 0, 8'h0A, 16'd0, 16'd0, 1, 18'd32768, 16'd0,
                idc_pkg::CLAMP_NONE, 0);
        add_row(1000, 16'h8000, 16'd256, 8'h0B, 16'd300, 16'd100, 0, 0, 0, 0, 0);
        add_row(1000, 16'h8000, 16'd256, 8'h0C, 16'd300, -16'sd100, 0, 0, 0, 0, 0);
        add_row(1000, 16'h7FFF, 16'd256, 8'h0D, -16'sd900, 16'h7FFF, 0, 0, 0, 0, 0);
        add_row(1000, 16'h7FFF, 16'd1, 8'h0E, 16'd900, 16'h8000, 0, 0, 0, 0, 0);
        add_row(1000, 16'h7FFF, 16'hFFFF, 8'h0F, 16'd10, 16'd1, 0, 0, 0, 0, 0);
        add_row(1000, 16'h7FFF, 16'hFFFF, 8'h10, 16'd10, 16'h7FFF, 0, 0, 0, 0, 0);
        add_row(1000, 16'd0, 16'd500, 8'h11, 16'd10, 16'd700, 0, 0, 0, 0, 0);
        add_row(1, 16'h7FFF, 0, 8'h12, 16'd1, 16'd1, 1, 18'd98303, 16'd1,
                idc_pkg::CLAMP_NONE, 0);
        add_row(1, 16'h8000, 0, 8'h13, 16'hFFFF, 16'd1, 1, 18'h38000, 16'hFFFF,
                idc_pkg::CLAMP_NONE, 0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[n]) begin
            i_s_axis_tvalid <= 1'b0;
            set_regs(rows[n].vdc, rows[n].amp, rows[n].tau);
            if (rows[n].fixed) begin
                expd = '{rows[n].chan, rows[n].duty, rows[n].cv, rows[n].state, rows[n].err};
                send_item(rows[n].chan, rows[n].v, rows[n].cur, expd);
            end else begin
                send_pred(rows[n].chan, rows[n].v, rows[n].cur);
            end
        end

        // Random phases: new settings every batch, extremes mixed in
        for (int ph = 0; ph < 15; ph++) begin
            i_s_axis_tvalid <= 1'b0;
            case ($urandom_range(0, 5))
                0: vdc = 15'h7FFF;
                1: vdc = 15'($urandom_range(0, 1));
                default: vdc = 15'($urandom_range(1, 32767));
            endcase
            case ($urandom_range(0, 5))
                0: amp = 16'h8000;
                1: amp = 16'h7FFF;
                2: amp = 16'h0000;
                default: amp = 16'($urandom());
            endcase
            case ($urandom_range(0, 5))
                0: tau = 16'h0000;
                1: tau = 16'hFFFF;
                default: tau = 16'($urandom_range(1, 4000));
            endcase
            set_regs(vdc, amp, tau);
            if (ph == 4) long_hold = 1'b1;
            if (ph == 13) begin
                src_idle_en = 1'b0;
                sink_idle_en = 1'b0;
            end
            for (int n = 0; n < RANDOM_ITEMS / 15; n++) begin
                v = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                    : 16'($signed(17'($urandom_range(0, 2 * vdc + 2)) - vdc - 1));
                cur = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                    : 16'($signed(17'($urandom_range(0, 2048))) - 17'sd1024);
                send_pred(8'($urandom()), v, cur);
            end
            // Sender pauses once until everything has come back
            if (ph == 7) begin
                i_s_axis_tvalid <= 1'b0;
                while (duty_queue.size() != 0) @(posedge i_clk);
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (duty_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (fail_count == 0 && !o_m_axis_tvalid) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
